### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcb assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcb assertion failed");

`endif

### hdl/tcb_pkg.sv
// Shared types, codes and helpers of the text cell buffer editor.
package tcb_pkg;

    // Request modes
    localparam logic [1:0] MODE_CHAR = 2'd0;
    localparam logic [1:0] MODE_KEY  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Navigation keys
    localparam logic [7:0] KEY_HOME   = 8'd0;
    localparam logic [7:0] KEY_END    = 8'd1;
    localparam logic [7:0] KEY_PGUP   = 8'd2;
    localparam logic [7:0] KEY_PGDN   = 8'd3;
    localparam logic [7:0] KEY_LEFT   = 8'd4;
    localparam logic [7:0] KEY_RIGHT  = 8'd5;
    localparam logic [7:0] KEY_UP     = 8'd6;
    localparam logic [7:0] KEY_DOWN   = 8'd7;
    localparam logic [7:0] KEY_DELETE = 8'd8;

    // Control characters
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_BLANK = 8'h20;

    // Register bus
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        KIND_PRINT,
        KIND_BS,
        KIND_TAB,
        KIND_LF,
        KIND_CR,
        KIND_ESC
    } kind_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUT_CODE,
        OP_PUT_BLANK,
        OP_LF,
        OP_CR,
        OP_KEY,
        OP_BS_LEFT,
        OP_DEL_START,
        OP_SH_RD,
        OP_SH_WR,
        OP_SH_END,
        OP_MOD_LOAD,
        OP_MOD_STEP,
        OP_CLR_START,
        OP_CLR_STEP,
        OP_RD_CELL
    } op_t;

    typedef struct packed {
        op_t  op;
        logic latch;
        logic rep_dec;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        kind_t      kind;
        logic       key_del;
        logic       rep_zero;
        logic       col_zero;
        logic       sh_done;
        logic       mod_done;
        logic       tab_end;
        logic       clr_last;
    } sts_t;

    function automatic kind_t char_kind(input logic [7:0] c);
        kind_t k;
        unique case (c)
            CH_BS:   k = KIND_BS;
            CH_TAB:  k = KIND_TAB;
            CH_LF:   k = KIND_LF;
            CH_CR:   k = KIND_CR;
            CH_ESC:  k = KIND_ESC;
            default: k = KIND_PRINT;
        endcase
        return k;
    endfunction

endpackage

### hdl/text_cell_buffer_editor.sv
// Top level of the text cell buffer editor: registers, controller and datapath.
//
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be held off by the receiver.
// Unless a register write is pending, busy is already low in the result
// cycle, so the next request can be taken at that same edge. A character
// request runs its repetitions one after another. A tab first takes the
// caret column modulo TAB_STOP by repeated subtraction, then writes spaces
// up to the next tab stop or the end of the row. A backspace moves the caret
// left and shifts the active cells right of the new caret one cell left, as
// the row shift goes through the cell memory one read and one write at a
// time. Delete shifts the active cells right of the caret the same way.
// Escape runs a clearing pass over the whole cell memory, one cell per cycle
// unless a register write restarts it. Reset and every register write run
// the same pass with busy high throughout; register writes are taken during it.
module text_cell_buffer_editor
    import tcb_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    parameter int TAB_STOP    = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            mode,
    input  logic [7:0]            code,
    input  logic [15:0]           repeat_count,
    input  logic [6:0]            read_column,
    input  logic [5:0]            read_row,
    output logic                  done,
    output logic [6:0]            caret_column,
    output logic [5:0]            caret_row,
    output logic [7:0]            cell_value,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_CW = $clog2(MAX_COLUMNS + 1);
    localparam int CNT_RW = $clog2(MAX_ROWS + 1);

    logic              cfg_wr;
    logic [CNT_CW-1:0] act_cols;
    logic [CNT_RW-1:0] act_rows;
    cmd_t              cmd;
    sts_t              sts;

    tcb_regs #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg_wr   (cfg_wr),
        .act_cols (act_cols),
        .act_rows (act_rows)
    );

    tcb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cfg_wr (cfg_wr),
        .sts    (sts),
        .busy   (busy),
        .cmd    (cmd)
    );

    tcb_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .TAB_STOP    (TAB_STOP)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .act_cols     (act_cols),
        .act_rows     (act_rows),
        .mode         (mode),
        .code         (code),
        .repeat_count (repeat_count),
        .read_column  (read_column),
        .read_row     (read_row),
        .sts          (sts),
        .done         (done),
        .caret_column (caret_column),
        .caret_row    (caret_row),
        .cell_value   (cell_value)
    );

endmodule

### hdl/tcb_regs.sv
// Configuration registers on the APB port and the clamped active screen size.
module tcb_regs
    import tcb_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    localparam int CNT_CW     = $clog2(MAX_COLUMNS + 1),
    localparam int CNT_RW     = $clog2(MAX_ROWS + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  cfg_wr,
    output logic [CNT_CW-1:0]     act_cols,
    output logic [CNT_RW-1:0]     act_rows
);

    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;
    localparam int   CMP_CW      = (CNT_CW > 8) ? CNT_CW : 8;
    localparam int   CMP_RW      = (CNT_RW > 7) ? CNT_RW : 7;

    logic [7:0] cols_reg;
    logic [6:0] rows_reg;
    logic       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign cfg_wr = wr;

    // Register write, decoded on the word address bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 8'd80;
            rows_reg <= 7'd25;
        end
        else if (wr)
        begin
            if (paddr[2] == REG_ROWS)
                rows_reg <= pwdata[6:0];
            else
                cols_reg <= pwdata[7:0];
        end
    end

    // Read back
    always_comb
    begin
        if (paddr[2] == REG_COLUMNS)
            prdata = {{(APB_DATA_W-8){1'b0}}, cols_reg};
        else
            prdata = {{(APB_DATA_W-7){1'b0}}, rows_reg};
    end

    // Zero counts as one, oversize counts as the maximum
    always_comb
    begin
        if (cols_reg == 8'd0)
            act_cols = CNT_CW'(1);
        else if (CMP_CW'(cols_reg) > CMP_CW'(MAX_COLUMNS))
            act_cols = CNT_CW'(MAX_COLUMNS);
        else
            act_cols = CNT_CW'(cols_reg);

        if (rows_reg == 7'd0)
            act_rows = CNT_RW'(1);
        else if (CMP_RW'(rows_reg) > CMP_RW'(MAX_ROWS))
            act_rows = CNT_RW'(MAX_ROWS);
        else
            act_rows = CNT_RW'(rows_reg);
    end

endmodule

### hdl/tcb_ctrl.sv
// Controller: sequences clears, repeats, tabs, row shifts and reads.
module tcb_ctrl
    import tcb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic cfg_wr,
    input  sts_t sts,
    output logic busy,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_REP,
        S_MOD,
        S_TAB_PUT,
        S_SH_RD,
        S_SH_WR,
        S_ESC_CLR,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   pend_reg;
    logic   pend_next;

    assign busy = busy_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next  = state_reg;
        pend_next   = pend_reg || cfg_wr;
        cmd.op      = OP_NONE;
        cmd.latch   = 1'b0;
        cmd.rep_dec = 1'b0;
        cmd.emit    = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                if (cfg_wr)
                    cmd.op = OP_CLR_START;
                else
                begin
                    cmd.op = OP_CLR_STEP;
                    if (sts.clr_last)
                        state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
                else if (cfg_wr)
                begin
                    cmd.op     = OP_CLR_START;
                    state_next = S_CLEAR;
                end
            end

            S_DISPATCH:
            begin
                unique case (sts.mode)
                    MODE_CHAR: state_next = S_REP;
                    MODE_KEY:
                    begin
                        if (sts.key_del)
                        begin
                            cmd.op     = OP_DEL_START;
                            state_next = S_SH_RD;
                        end
                        else
                        begin
                            cmd.op     = OP_KEY;
                            state_next = S_EMIT;
                        end
                    end
                    MODE_READ:
                    begin
                        cmd.op     = OP_RD_CELL;
                        state_next = S_EMIT;
                    end
                    default: state_next = S_EMIT;
                endcase
            end

            // One repetition of a character request
            S_REP:
            begin
                if (sts.rep_zero)
                    state_next = S_EMIT;
                else
                begin
                    unique case (sts.kind)
                        KIND_PRINT:
                        begin
                            cmd.op      = OP_PUT_CODE;
                            cmd.rep_dec = 1'b1;
                        end
                        KIND_LF:
                        begin
                            cmd.op      = OP_LF;
                            cmd.rep_dec = 1'b1;
                        end
                        KIND_CR:
                        begin
                            cmd.op      = OP_CR;
                            cmd.rep_dec = 1'b1;
                        end
                        KIND_TAB:
                        begin
                            cmd.op      = OP_MOD_LOAD;
                            cmd.rep_dec = 1'b1;
                            state_next  = S_MOD;
                        end
                        KIND_BS:
                        begin
                            if (sts.col_zero)
                                state_next = S_EMIT;
                            else
                            begin
                                cmd.op      = OP_BS_LEFT;
                                cmd.rep_dec = 1'b1;
                                state_next  = S_SH_RD;
                            end
                        end
                        KIND_ESC:
                        begin
                            cmd.op     = OP_CLR_START;
                            state_next = S_ESC_CLR;
                        end
                    endcase
                end
            end

            // Caret column modulo the tab stop, by repeated subtraction
            S_MOD:
            begin
                if (sts.mod_done)
                    state_next = S_TAB_PUT;
                else
                    cmd.op = OP_MOD_STEP;
            end

            S_TAB_PUT:
            begin
                cmd.op = OP_PUT_BLANK;
                if (sts.tab_end)
                    state_next = S_REP;
            end

            // Row shift: read the right neighbor, then write it one cell left
            S_SH_RD:
            begin
                if (sts.sh_done)
                begin
                    cmd.op = OP_SH_END;
                    if (sts.mode == MODE_CHAR)
                        state_next = S_REP;
                    else
                        state_next = S_EMIT;
                end
                else
                begin
                    cmd.op     = OP_SH_RD;
                    state_next = S_SH_WR;
                end
            end

            S_SH_WR:
            begin
                cmd.op     = OP_SH_WR;
                state_next = S_SH_RD;
            end

            S_ESC_CLR:
            begin
                if (cfg_wr)
                    cmd.op = OP_CLR_START;
                else
                begin
                    cmd.op = OP_CLR_STEP;
                    if (sts.clr_last)
                        state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (pend_reg || cfg_wr)
                begin
                    cmd.op     = OP_CLR_START;
                    state_next = S_CLEAR;
                end
                else
                    state_next = S_IDLE;
            end
        endcase

        if (cmd.op == OP_CLR_START)
            pend_next = 1'b0;
    end

    // State and registered outputs; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            pend_reg  <= pend_next;
        end
    end

endmodule

### hdl/tcb_datapath.sv
// Datapath: cell memory, caret, repeat and shift counters, result registers.
module tcb_datapath
    import tcb_pkg::*;
#(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64,
    parameter int TAB_STOP    = 8,
    localparam int CNT_CW     = $clog2(MAX_COLUMNS + 1),
    localparam int CNT_RW     = $clog2(MAX_ROWS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [CNT_CW-1:0] act_cols,
    input  logic [CNT_RW-1:0] act_rows,
    input  logic [1:0]        mode,
    input  logic [7:0]        code,
    input  logic [15:0]       repeat_count,
    input  logic [6:0]        read_column,
    input  logic [5:0]        read_row,
    output sts_t              sts,
    output logic              done,
    output logic [6:0]        caret_column,
    output logic [5:0]        caret_row,
    output logic [7:0]        cell_value
);

    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int PH_W   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int PX     = ((COL_W > PH_W) ? COL_W : PH_W) + 1;
    localparam int CMP_CW = (CNT_CW > 7) ? CNT_CW : 7;
    localparam int CMP_RW = (CNT_RW > 6) ? CNT_RW : 6;

    // Cell memory
    logic [7:0]        mem [DEPTH];
    logic [7:0]        rdata_reg;
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        wdata;

    // Latched request
    logic [1:0]  mode_reg;
    logic [7:0]  code_reg;
    logic [15:0] rep_reg;
    logic [6:0]  rcol_reg;
    logic [5:0]  rrow_reg;

    // Caret and working counters
    logic [COL_W-1:0]  caret_col_reg;
    logic [COL_W-1:0]  caret_col_next;
    logic [ROW_W-1:0]  caret_row_reg;
    logic [ROW_W-1:0]  caret_row_next;
    logic [COL_W-1:0]  x_reg;
    logic [COL_W-1:0]  x_next;
    logic [PX-1:0]     phase_reg;
    logic [PX-1:0]     phase_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    // Results
    logic       done_reg;
    logic [6:0] res_col_reg;
    logic [5:0] res_row_reg;
    logic [7:0] res_cell_reg;

    // Caret arithmetic
    logic [COL_W:0]    cols_x;
    logic [ROW_W:0]    rows_x;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    x_inc;
    logic              col_wrap;
    logic              row_wrap;
    logic [ROW_W-1:0]  row_adv;
    logic [COL_W-1:0]  col_last;
    logic [ROW_W-1:0]  row_last;
    logic [PX-1:0]     ph_inc;
    logic [PX-1:0]     ph_wrapped;
    logic [ADDR_W-1:0] caret_addr;
    logic              in_area;

    assign cols_x     = (COL_W+1)'(act_cols);
    assign rows_x     = (ROW_W+1)'(act_rows);
    assign col_inc    = {1'b0, caret_col_reg} + (COL_W+1)'(1);
    assign row_inc    = {1'b0, caret_row_reg} + (ROW_W+1)'(1);
    assign x_inc      = {1'b0, x_reg} + (COL_W+1)'(1);
    assign col_wrap   = (col_inc >= cols_x);
    assign row_wrap   = (row_inc >= rows_x);
    assign row_adv    = row_wrap ? '0 : row_inc[ROW_W-1:0];
    assign col_last   = COL_W'(cols_x - (COL_W+1)'(1));
    assign row_last   = ROW_W'(rows_x - (ROW_W+1)'(1));
    assign ph_inc     = phase_reg + PX'(1);
    assign ph_wrapped = (ph_inc == PX'(TAB_STOP)) ? '0 : ph_inc;
    assign caret_addr = {caret_row_reg, caret_col_reg};
    assign in_area    = (CMP_CW'(rcol_reg) < CMP_CW'(act_cols))
                     && (CMP_RW'(rrow_reg) < CMP_RW'(act_rows));

    // Status to the controller
    assign sts.mode     = mode_reg;
    assign sts.kind     = char_kind(code_reg);
    assign sts.key_del  = (code_reg == KEY_DELETE);
    assign sts.rep_zero = (rep_reg == 16'd0);
    assign sts.col_zero = (caret_col_reg == '0);
    assign sts.sh_done  = (x_inc >= cols_x);
    assign sts.mod_done = (phase_reg < PX'(TAB_STOP));
    assign sts.tab_end  = col_wrap || (ph_wrapped == '0);
    assign sts.clr_last = &clr_addr_reg;

    // Operation decode
    always_comb
    begin
        caret_col_next = caret_col_reg;
        caret_row_next = caret_row_reg;
        x_next         = x_reg;
        phase_next     = phase_reg;
        clr_addr_next  = clr_addr_reg;
        we             = 1'b0;
        re             = 1'b0;
        waddr          = caret_addr;
        raddr          = caret_addr;
        wdata          = CH_BLANK;

        unique case (cmd.op)
            OP_NONE: ;

            OP_PUT_CODE, OP_PUT_BLANK:
            begin
                we = 1'b1;
                if (cmd.op == OP_PUT_CODE)
                    wdata = code_reg;
                if (col_wrap)
                begin
                    caret_col_next = '0;
                    caret_row_next = row_adv;
                end
                else
                    caret_col_next = col_inc[COL_W-1:0];
                if (cmd.op == OP_PUT_BLANK)
                    phase_next = col_wrap ? '0 : ph_wrapped;
            end

            OP_LF:
                caret_row_next = row_adv;

            OP_CR:
            begin
                caret_col_next = '0;
                caret_row_next = row_adv;
            end

            OP_KEY:
            begin
                unique case (code_reg)
                    KEY_HOME:  caret_col_next = '0;
                    KEY_END:   caret_col_next = col_last;
                    KEY_PGUP:  caret_row_next = '0;
                    KEY_PGDN:  caret_row_next = row_last;
                    KEY_LEFT:
                    begin
                        if (caret_col_reg != '0)
                            caret_col_next = caret_col_reg - COL_W'(1);
                    end
                    KEY_RIGHT:
                    begin
                        if (!col_wrap)
                            caret_col_next = col_inc[COL_W-1:0];
                    end
                    KEY_UP:
                    begin
                        if (caret_row_reg != '0)
                            caret_row_next = caret_row_reg - ROW_W'(1);
                    end
                    KEY_DOWN:
                    begin
                        if (!row_wrap)
                            caret_row_next = row_inc[ROW_W-1:0];
                    end
                    default: ;
                endcase
            end

            OP_BS_LEFT:
            begin
                caret_col_next = caret_col_reg - COL_W'(1);
                x_next         = caret_col_reg - COL_W'(1);
            end

            OP_DEL_START:
                x_next = caret_col_reg;

            OP_SH_RD:
            begin
                re    = 1'b1;
                raddr = {caret_row_reg, x_inc[COL_W-1:0]};
            end

            OP_SH_WR:
            begin
                we     = 1'b1;
                waddr  = {caret_row_reg, x_reg};
                wdata  = rdata_reg;
                x_next = x_inc[COL_W-1:0];
            end

            OP_SH_END:
            begin
                we    = 1'b1;
                waddr = {caret_row_reg, col_last};
            end

            OP_MOD_LOAD:
                phase_next = PX'(caret_col_reg);

            OP_MOD_STEP:
                phase_next = phase_reg - PX'(TAB_STOP);

            OP_CLR_START:
            begin
                clr_addr_next  = '0;
                caret_col_next = '0;
                caret_row_next = '0;
            end

            OP_CLR_STEP:
            begin
                we            = 1'b1;
                waddr         = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end

            OP_RD_CELL:
            begin
                re    = 1'b1;
                raddr = {ROW_W'(rrow_reg), COL_W'(rcol_reg)};
            end
        endcase
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // Request latch and repeat counter
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= mode;
            code_reg <= code;
            rep_reg  <= repeat_count;
            rcol_reg <= read_column;
            rrow_reg <= read_row;
        end
        else if (cmd.rep_dec)
            rep_reg <= rep_reg - 16'd1;
    end

    // Caret and sweep address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caret_col_reg <= '0;
            caret_row_reg <= '0;
            clr_addr_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            caret_col_reg <= caret_col_next;
            caret_row_reg <= caret_row_next;
            clr_addr_reg  <= clr_addr_next;
            done_reg      <= cmd.emit;
        end
    end

    // Shift index and tab phase
    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        phase_reg <= phase_next;
    end

    // Result capture
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_col_reg <= 7'(caret_col_reg);
            res_row_reg <= 6'(caret_row_reg);
            if (mode_reg == MODE_READ && in_area)
                res_cell_reg <= rdata_reg;
            else
                res_cell_reg <= 8'd0;
        end
    end

    assign done         = done_reg;
    assign caret_column = res_col_reg;
    assign caret_row    = res_row_reg;
    assign cell_value   = res_cell_reg;

endmodule

### hdl/tcb_checker.sv
// Port-level checker for the text cell buffer editor and its bind.
`include "assert_macros.svh"

module tcb_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic psel,
    input logic penable,
    input logic pwrite,
    input logic pready
);

    // A taken request makes the block busy right after it is taken
    `TCB_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // Results only come out of work that was in progress
    `TCB_ASSERT_IMP(a_done_from_busy, done, $past(busy))

    // One result per request: done always drops again right after it rises
    `TCB_ASSERT_NEXT(a_done_single, done, !done)

    // A register write always leads to a clearing pass and leaves the block busy
    `TCB_ASSERT_NEXT(a_cfg_clears, psel && penable && pwrite && pready, busy)

endmodule

bind text_cell_buffer_editor tcb_checker u_tcb_checker (.*);
